[design/cct_pkg.sv]
// ----------------------------------------------------------------------------
// cct_pkg: shared definitions for the cluster chain table
// Operation codes, the chain-end marker, configuration defaults and the flag
// bundle that the compare unit returns to the sequencer.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam int unsigned DEF_MAX_CLUSTERS = 1024;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CFG_W   = 11;

    localparam logic [CFG_W-1:0]  CFG_RESET = 11'd1024;
    localparam logic [DATA_W-1:0] CHAIN_END = 32'hFFFF_FFFF;

    localparam logic [KIND_W-1:0] KIND_NEXT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd3;

    typedef struct packed {
        logic below;      // operand is a valid cluster index
        logic chain_end;  // operand is the chain-end marker
    } cmp_flags_t;

endpackage

[design/cct_if.sv]
// ----------------------------------------------------------------------------
// cct_if: request and response channels of the cluster chain table
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface cct_req_if;
    logic                             valid;
    logic                             ready;
    logic [cct_pkg::KIND_W-1:0]       kind;
    logic [cct_pkg::DATA_W-1:0]       cluster;
    logic [cct_pkg::DATA_W-1:0]       entry_value;

    modport source (output valid, kind, cluster, entry_value, input ready);
    modport sink   (input valid, kind, cluster, entry_value, output ready);
endinterface

interface cct_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [cct_pkg::DATA_W-1:0]       result_cluster;
    logic                             at_end;

    modport source (output valid, result_cluster, at_end, input ready);
    modport sink   (input valid, result_cluster, at_end, output ready);
endinterface

[design/cct_fat_ram.sv]
// ----------------------------------------------------------------------------
// cct_fat_ram: allocation table storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cct_fat_ram #(
    parameter int unsigned DEPTH  = cct_pkg::DEF_MAX_CLUSTERS,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [cct_pkg::DATA_W-1:0]  wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [cct_pkg::DATA_W-1:0]  rdata
);

    logic [cct_pkg::DATA_W-1:0] mem [DEPTH];
    logic [cct_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/cct_cmp_unit.sv]
// ----------------------------------------------------------------------------
// cct_cmp_unit: shared cluster index compare
// Checks one operand against the effective cluster count and the chain-end
// marker; the sequencer steers requested index, link or scan index into it.
// ----------------------------------------------------------------------------
module cct_cmp_unit #(
    parameter int unsigned CNT_W = 11
) (
    input  logic [cct_pkg::DATA_W-1:0] operand,
    input  logic [CNT_W-1:0]           eff_count,
    output cct_pkg::cmp_flags_t        flags
);

    always_comb
    begin
        flags.below     = (operand < cct_pkg::DATA_W'(eff_count));
        flags.chain_end = (operand == cct_pkg::CHAIN_END);
    end

endmodule

[design/cct_ctrl.sv]
// ----------------------------------------------------------------------------
// cct_ctrl: operation sequencer of the cluster chain table
// Runs the clearing pass, decodes each request, walks the table for a free
// entry one address per cycle and holds the response register.
// ----------------------------------------------------------------------------
module cct_ctrl #(
    parameter int unsigned MAX_CLUSTERS = cct_pkg::DEF_MAX_CLUSTERS,
    parameter int unsigned IDX_W        = $clog2(MAX_CLUSTERS),
    parameter int unsigned CNT_W        = $clog2(MAX_CLUSTERS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [cct_pkg::CFG_W-1:0]   cfg_wr_data,
    cct_req_if.sink                     req,
    cct_rsp_if.source                   rsp,
    output logic                        ram_we,
    output logic [IDX_W-1:0]            ram_waddr,
    output logic [cct_pkg::DATA_W-1:0]  ram_wdata,
    output logic [IDX_W-1:0]            ram_raddr,
    input  logic [cct_pkg::DATA_W-1:0]  ram_rdata,
    output logic [cct_pkg::DATA_W-1:0]  cmp_operand,
    output logic [CNT_W-1:0]            eff_count,
    input  cct_pkg::cmp_flags_t         cmp_flags
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_LINK     = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_LINKW    = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_CLUSTERS - 1);
    localparam logic [CNT_W-1:0] EFF_RESET =
        (int'(cct_pkg::CFG_RESET) > MAX_CLUSTERS) ? CNT_W'(MAX_CLUSTERS)
                                                  : CNT_W'(cct_pkg::CFG_RESET);

    logic [2:0]                      state_reg, state_next;
    logic [IDX_W-1:0]                clr_reg, clr_next;
    logic [CNT_W-1:0]                eff_reg, eff_next;
    logic                            out_valid_reg, out_valid_next;

    logic [cct_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic [cct_pkg::DATA_W-1:0]      clu_reg, clu_next;
    logic [cct_pkg::DATA_W-1:0]      val_reg, val_next;
    logic [IDX_W-1:0]                scan_reg, scan_next;
    logic [cct_pkg::DATA_W-1:0]      res_reg, res_next;
    logic [cct_pkg::DATA_W-1:0]      out_res_reg, out_res_next;
    logic                            out_end_reg, out_end_next;

    logic [IDX_W:0]                  scan_plus;

    assign scan_plus = {1'b0, scan_reg} + (IDX_W + 1)'(1);
    assign eff_count = eff_reg;

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.result_cluster = out_res_reg;
    assign rsp.at_end         = out_end_reg;

    // The effective count is saturated once, when the register is written.
    always_comb
    begin
        eff_next = eff_reg;
        if (cfg_wr_en)
        begin
            if (int'(cfg_wr_data) > MAX_CLUSTERS)
            begin
                eff_next = CNT_W'(MAX_CLUSTERS);
            end
            else
            begin
                eff_next = CNT_W'(cfg_wr_data);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        clu_next       = clu_reg;
        val_next       = val_reg;
        scan_next      = scan_reg;
        res_next       = res_reg;
        out_res_next   = out_res_reg;
        out_end_next   = out_end_reg;
        ram_we         = 1'b0;
        ram_waddr      = scan_reg;
        ram_wdata      = '0;
        ram_raddr      = scan_reg;
        cmp_operand    = clu_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    clu_next   = req.cluster;
                    val_next   = req.entry_value;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_next   = cct_pkg::CHAIN_END;
                state_next = S_DONE;
                case (kind_reg)
                    cct_pkg::KIND_NEXT:
                    begin
                        if (cmp_flags.below)
                        begin
                            ram_raddr  = clu_reg[IDX_W-1:0];
                            state_next = S_LINK;
                        end
                    end
                    cct_pkg::KIND_ALLOC, cct_pkg::KIND_APPEND:
                    begin
                        // Append after chain end is a plain allocation.
                        if ((kind_reg == cct_pkg::KIND_ALLOC) || cmp_flags.below
                            || cmp_flags.chain_end)
                        begin
                            scan_next = '0;
                            ram_raddr = '0;
                            if (eff_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    end
                    default:
                    begin
                        if (cmp_flags.below)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = clu_reg[IDX_W-1:0];
                            ram_wdata = val_reg;
                            res_next  = clu_reg;
                        end
                    end
                endcase
            end
            S_LINK:
            begin
                cmp_operand = ram_rdata;
                res_next    = cmp_flags.below ? ram_rdata : cct_pkg::CHAIN_END;
                state_next  = S_DONE;
            end
            S_SCAN:
            begin
                // Read data holds the entry at scan_reg; the next address is
                // read in the same cycle so the walk runs one entry per cycle.
                cmp_operand = cct_pkg::DATA_W'(scan_plus);
                if (ram_rdata == '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = scan_reg;
                    ram_wdata = cct_pkg::CHAIN_END;
                    res_next  = cct_pkg::DATA_W'(scan_reg);
                    if ((kind_reg == cct_pkg::KIND_APPEND)
                        && (clu_reg != cct_pkg::CHAIN_END))
                    begin
                        state_next = S_LINKW;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (!cmp_flags.below)
                begin
                    res_next   = cct_pkg::CHAIN_END;
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next = scan_plus[IDX_W-1:0];
                    ram_raddr = scan_plus[IDX_W-1:0];
                end
            end
            S_LINKW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = clu_reg[IDX_W-1:0];
                ram_wdata  = cct_pkg::DATA_W'(scan_reg);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_end_next   = (res_reg == cct_pkg::CHAIN_END);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            eff_reg       <= EFF_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            eff_reg       <= eff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        clu_reg     <= clu_next;
        val_reg     <= val_next;
        scan_reg    <= scan_next;
        res_reg     <= res_next;
        out_res_reg <= out_res_next;
        out_end_reg <= out_end_next;
    end

endmodule

[design/cluster_chain_table.sv]
// Next from a valid cluster runs decode, link read and done states before the response
// register; load, and any request rejected at decode, runs decode and done; allocate
// and append walk the table entry by entry, and append adds a state that writes the link.
// Requests are taken one at a time; the free-entry walk goes through the single table
// read port and covers at most the effective cluster count. Reset: a
// clearing pass zeroes all MAX_CLUSTERS entries, one per cycle, before any request.
// ----------------------------------------------------------------------------
// cluster_chain_table: cluster allocation table with chain operations
// Follows, allocates, appends and loads table entries through one shared
// compare unit and a table with one read and one write port under a small sequencer.
// ----------------------------------------------------------------------------
module cluster_chain_table #(
    parameter int unsigned MAX_CLUSTERS = cct_pkg::DEF_MAX_CLUSTERS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [cct_pkg::CFG_W-1:0]   cfg_wr_data,
    cct_req_if.sink                     req,
    cct_rsp_if.source                   rsp
);

    localparam int unsigned IDX_W = $clog2(MAX_CLUSTERS);
    localparam int unsigned CNT_W = $clog2(MAX_CLUSTERS + 1);

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [cct_pkg::DATA_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]            ram_raddr;
    logic [cct_pkg::DATA_W-1:0]  ram_rdata;
    logic [cct_pkg::DATA_W-1:0]  cmp_operand;
    logic [CNT_W-1:0]            eff_count;
    cct_pkg::cmp_flags_t         cmp_flags;

    cct_fat_ram #(
        .DEPTH  (MAX_CLUSTERS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cct_cmp_unit #(
        .CNT_W (CNT_W)
    ) u_cmp (
        .operand   (cmp_operand),
        .eff_count (eff_count),
        .flags     (cmp_flags)
    );

    cct_ctrl #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp         (rsp),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .cmp_operand (cmp_operand),
        .eff_count   (eff_count),
        .cmp_flags   (cmp_flags)
    );

endmodule
